// ===== rtl/core/tile_dedup_adjacency_rules_macros.svh =====
// assertion macros for the tile dedup and adjacency rule block
// no dependencies; the bodies drop out when SYNTHESIS is defined
`ifndef TILE_DEDUP_ADJACENCY_RULES_MACROS_SVH
`define TILE_DEDUP_ADJACENCY_RULES_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TDAR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdar assertion failed");
// next-cycle implication
`define TDAR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdar assertion failed");
`else
`define TDAR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TDAR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/tdar_pkg.sv =====
// shared types and constants of the tile dedup and adjacency rule block
// no dependencies
`default_nettype none
package tdar_pkg;

   localparam int OP_W      = 2;
   localparam int KEY_W     = 32;
   localparam int QID_W     = 6;
   localparam int DIR_W     = 2;
   localparam int TILE_ID_W = 6;
   localparam int COUNT_W   = 7;
   localparam int ROW_W     = 64;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int ROW_POS_W = 6;
   localparam int NUM_DIRS  = 4;
   localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;
   localparam logic [CFG_W-1:0] MAX_ROWS   = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_TILE  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLUMNS = 1'b0,
      CSR_GRID_ROWS    = 1'b1
   } csr_index_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_RESOLVE,
      ST_UPDATE,
      ST_QUERY,
      ST_QOUT,
      ST_OTHER
   } state_type;

   typedef struct packed {
      logic match_en;
      logic insert;
   } chain_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } bank_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/core/tdar_key_cell.sv =====
// one cell of the key chain: a stored key with its id and a registered hit flag
// depends on tdar_pkg
`default_nettype none
module tdar_key_cell #(
   parameter int KW  = 32,
   parameter int IDW = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdar_pkg::chain_ctl_type ctl,
   input  logic                    occupied,
   input  logic [KW-1:0]           search_key,
   input  logic [KW-1:0]           prev_key,
   input  logic [IDW-1:0]          prev_id,
   output logic [KW-1:0]           key_out,
   output logic [IDW-1:0]          id_out,
   output logic                    hit,
   output logic [IDW-1:0]          hit_id
);

   logic [KW-1:0]  key_ff, key_in;
   logic [IDW-1:0] id_ff, id_in;
   logic           hit_ff, hit_in;

   always_comb begin
      key_in = ctl.insert ? prev_key : key_ff;
      id_in  = ctl.insert ? prev_id : id_ff;
      hit_in = ctl.match_en ? (occupied && (key_ff == search_key)) : hit_ff;
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign key_out = key_ff;
   assign id_out  = id_ff;
   assign hit     = hit_ff;
   assign hit_id  = hit_ff ? id_ff : '0;

endmodule
`default_nettype wire

// ===== rtl/core/tdar_key_chain.sv =====
// row of key cells: new keys shift in at cell 0, all cells compare in parallel
// depends on tdar_pkg and tdar_key_cell
`default_nettype none
module tdar_key_chain #(
   parameter int N   = 64,
   parameter int KW  = 32,
   parameter int IDW = 6,
   parameter int IUW = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tdar_pkg::chain_ctl_type ctl,
   input  logic [KW-1:0]           key,
   input  logic [IDW-1:0]          new_id,
   input  logic [IUW-1:0]          ids_used,
   output logic                    found,
   output logic [IDW-1:0]          match_id
);

   logic [KW-1:0]  key_link [N];
   logic [IDW-1:0] id_link  [N];
   logic [N-1:0]   hit;
   logic [IDW-1:0] hit_id   [N];

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [KW-1:0]  prev_key;
      logic [IDW-1:0] prev_id;
      logic           occupied;

      if (i == 0) begin : g_head
         assign prev_key = key;
         assign prev_id  = new_id;
      end else begin : g_body
         assign prev_key = key_link[i-1];
         assign prev_id  = id_link[i-1];
      end

      // cell i holds a key only once i+1 ids are in use
      assign occupied = IUW'(i) < ids_used;

      tdar_key_cell #(
         .KW  (KW),
         .IDW (IDW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .occupied   (occupied),
         .search_key (key),
         .prev_key   (prev_key),
         .prev_id    (prev_id),
         .key_out    (key_link[i]),
         .id_out     (id_link[i]),
         .hit        (hit[i]),
         .hit_id     (hit_id[i])
      );
   end

   // keys are unique, so at most one cell hits and an or merges the ids
   always_comb begin
      match_id = '0;
      for (int j = 0; j < N; j++) begin
         match_id = match_id | hit_id[j];
      end
   end

   assign found = |hit;

endmodule
`default_nettype wire

// ===== rtl/core/tdar_rule_bank.sv =====
// one direction bank of the rule table: memory with registered read and per-row valid bits
// depends on tdar_pkg
`default_nettype none
module tdar_rule_bank #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int WIDTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tdar_pkg::bank_ctl_type ctl,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // a row never written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule
`default_nettype wire

// ===== rtl/core/tile_dedup_adjacency_rules.sv =====
// top level: tile key dedup into ids, line buffer and left register, adjacency rule table
// depends on tdar_pkg, tdar_key_chain, tdar_rule_bank and the assertion macro header
// tile word: compare in the key chain, id resolve with rule bank reads, then one
//   read-modify-write per rule bank; the next word is taken only back in idle
// query word: one bank read; clear or no-op word: no bank read
// reset: synchronous, active high; drops all ids, rule rows and position, grid size to 64
`default_nettype none
`include "tile_dedup_adjacency_rules_macros.svh"
module tile_dedup_adjacency_rules #(
   parameter int MAX_IDS     = 64,
   parameter int MAX_COLUMNS = 64,
   parameter int KEY_BITS    = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input word channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tdar_pkg::OP_W-1:0]         req_op,
   input  logic [tdar_pkg::KEY_W-1:0]        req_tile_key,
   input  logic [tdar_pkg::QID_W-1:0]        req_query_id,
   input  logic [tdar_pkg::DIR_W-1:0]        req_query_dir,
   // result word channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tdar_pkg::TILE_ID_W-1:0]    rsp_tile_id,
   output logic                              rsp_is_new,
   output logic                              rsp_overflow,
   output logic                              rsp_last_tile,
   output logic [tdar_pkg::ROW_W-1:0]        rsp_allowed_row,
   output logic [tdar_pkg::COUNT_W-1:0]      rsp_distinct_count,
   // register write port
   input  logic                              csr_wen,
   input  logic [tdar_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdar_pkg::CFG_W-1:0]        csr_wdata
);

   // widths that follow from the parameters
   localparam int IDW    = $clog2(MAX_IDS);
   localparam int IUW    = $clog2(MAX_IDS + 1);
   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CNT_W  = (COL_W + 1 > tdar_pkg::CFG_W) ? COL_W + 1 : tdar_pkg::CFG_W;
   localparam int KW     = (KEY_BITS < tdar_pkg::KEY_W) ? KEY_BITS : tdar_pkg::KEY_W;
   localparam int LB_W   = IDW + 1;
   localparam int NDIR   = tdar_pkg::NUM_DIRS;
   localparam int CFG_W  = tdar_pkg::CFG_W;
   localparam int RP_W   = tdar_pkg::ROW_POS_W;
   localparam int ROW_W  = tdar_pkg::ROW_W;
   localparam int TID_W  = tdar_pkg::TILE_ID_W;
   localparam int CNTO_W = tdar_pkg::COUNT_W;
   localparam int QCMP_W = tdar_pkg::QID_W + 1;

   // control state
   tdar_pkg::state_type state_ff, state_in;

   // captured input word
   tdar_pkg::op_type            op_ff;
   logic [KW-1:0]               key_ff;
   logic [tdar_pkg::QID_W-1:0]  qid_ff;
   logic [tdar_pkg::DIR_W-1:0]  qdir_ff;

   // grid registers and position
   logic [CFG_W-1:0] cols_ff, rows_ff;
   logic [COL_W-1:0] col_ff;
   logic [RP_W-1:0]  row_ff;
   logic [IUW-1:0]   ids_used_ff;
   logic [IDW-1:0]   left_id_ff;
   logic             left_valid_ff;

   // line buffer for the row above: {valid, id} per column
   logic [LB_W-1:0] lb_mem [MAX_COLUMNS];
   logic [LB_W-1:0] lb_rd_ff;

   // resolved tile, held for the write cycle
   logic [IDW-1:0] tid_ff;
   logic           new_ff, ovf_ff, rec_ff;
   logic           link_up_ff, link_left_ff;
   logic [IDW-1:0] addr_ff [NDIR];
   logic [IDW-1:0] bit_ff  [NDIR];

   // result register
   logic                rsp_valid_ff;
   logic [TID_W-1:0]    rsp_tile_id_ff, rsp_tile_id_in;
   logic                rsp_is_new_ff, rsp_is_new_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [ROW_W-1:0]    rsp_row_ff, rsp_row_in;
   logic [CNTO_W-1:0]   rsp_count_ff, rsp_count_in;

   // handshake and sequencing strobes
   logic accept, out_free;
   logic update_fire, qout_fire, other_fire, rsp_load;

   // key chain
   tdar_pkg::chain_ctl_type chain_ctl;
   logic                    chain_found;
   logic [IDW-1:0]          chain_id;

   // rule banks, indexed by direction
   tdar_pkg::bank_ctl_type bank_ctl [NDIR];
   logic [IDW-1:0]         bank_rd_addr [NDIR];
   logic [IDW-1:0]         link_bit [NDIR];
   logic [MAX_IDS-1:0]     bank_wdata [NDIR];
   logic [MAX_IDS-1:0]     bank_rdata [NDIR];

   // resolve step
   logic           full;
   logic [IDW-1:0] res_id, above_id;
   logic           res_ovf, res_rec, above_valid;
   logic           link_up, link_left;

   // effective grid size and position steps
   logic [CNT_W-1:0] cols_ext, eff_cols, col_next;
   logic [CFG_W-1:0] eff_rows, row_next;
   logic             col_wrap, row_wrap, qid_ok;

   assign accept   = req_valid && req_ready;
   // result register is free, or its word leaves this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // clamp the grid size: zero acts as one, columns stop at the buffer, rows at MAX_ROWS
   always_comb begin
      cols_ext = CNT_W'(cols_ff);
      if (cols_ff == '0) begin
         eff_cols = CNT_W'(1);
      end else if (cols_ext > CNT_W'(MAX_COLUMNS)) begin
         eff_cols = CNT_W'(MAX_COLUMNS);
      end else begin
         eff_cols = cols_ext;
      end
      if (rows_ff == '0) begin
         eff_rows = CFG_W'(1);
      end else if (rows_ff > tdar_pkg::MAX_ROWS) begin
         eff_rows = tdar_pkg::MAX_ROWS;
      end else begin
         eff_rows = rows_ff;
      end
      col_next = CNT_W'(col_ff) + CNT_W'(1);
      row_next = CFG_W'(row_ff) + CFG_W'(1);
      col_wrap = col_next == eff_cols;
      row_wrap = row_next == eff_rows;
   end

   // id resolve from the registered chain hits
   always_comb begin
      full        = ids_used_ff == IUW'(MAX_IDS);
      res_ovf     = !chain_found && full;
      res_rec     = !res_ovf;
      if (chain_found) begin
         res_id = chain_id;
      end else if (full) begin
         res_id = '0;
      end else begin
         res_id = ids_used_ff[IDW-1:0];
      end
      above_valid = lb_rd_ff[LB_W-1];
      above_id    = lb_rd_ff[IDW-1:0];
      // no up link in the top row, no left link in the first column
      link_up     = res_rec && (row_ff != '0) && above_valid;
      link_left   = res_rec && (col_ff != '0) && left_valid_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tdar_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (tdar_pkg::op_type'(req_op))
                  tdar_pkg::OP_TILE:  state_in = tdar_pkg::ST_MATCH;
                  tdar_pkg::OP_QUERY: state_in = tdar_pkg::ST_QUERY;
                  default:            state_in = tdar_pkg::ST_OTHER;
               endcase
            end
         end
         tdar_pkg::ST_MATCH:   state_in = tdar_pkg::ST_RESOLVE;
         tdar_pkg::ST_RESOLVE: state_in = tdar_pkg::ST_UPDATE;
         tdar_pkg::ST_UPDATE: begin
            if (out_free) begin
               state_in = tdar_pkg::ST_IDLE;
            end
         end
         tdar_pkg::ST_QUERY: state_in = tdar_pkg::ST_QOUT;
         tdar_pkg::ST_QOUT: begin
            if (out_free) begin
               state_in = tdar_pkg::ST_IDLE;
            end
         end
         tdar_pkg::ST_OTHER: begin
            if (out_free) begin
               state_in = tdar_pkg::ST_IDLE;
            end
         end
         default: state_in = tdar_pkg::ST_IDLE;
      endcase
   end

   // state outputs: strobes, chain control and bank ports
   always_comb begin
      req_ready          = 1'b0;
      update_fire        = 1'b0;
      qout_fire          = 1'b0;
      other_fire         = 1'b0;
      chain_ctl.match_en = 1'b0;
      chain_ctl.insert   = 1'b0;
      case (state_ff)
         tdar_pkg::ST_IDLE:    req_ready          = 1'b1;
         tdar_pkg::ST_MATCH:   chain_ctl.match_en = 1'b1;
         tdar_pkg::ST_RESOLVE: chain_ctl.insert   = !chain_found && !full;
         tdar_pkg::ST_UPDATE:  update_fire        = out_free;
         tdar_pkg::ST_QOUT:    qout_fire          = out_free;
         tdar_pkg::ST_OTHER:   other_fire         = out_free;
         default: ;
      endcase
      rsp_load = update_fire || qout_fire || other_fire;

      // resolve reads the four rows a tile may touch; a query reads the same row everywhere
      if (state_ff == tdar_pkg::ST_QUERY) begin
         for (int b = 0; b < NDIR; b++) begin
            bank_rd_addr[b] = qid_ff[IDW-1:0];
         end
      end else begin
         bank_rd_addr[tdar_pkg::DIR_UP]    = res_id;
         bank_rd_addr[tdar_pkg::DIR_DOWN]  = above_id;
         bank_rd_addr[tdar_pkg::DIR_LEFT]  = res_id;
         bank_rd_addr[tdar_pkg::DIR_RIGHT] = left_id_ff;
      end
      link_bit[tdar_pkg::DIR_UP]    = above_id;
      link_bit[tdar_pkg::DIR_DOWN]  = res_id;
      link_bit[tdar_pkg::DIR_LEFT]  = left_id_ff;
      link_bit[tdar_pkg::DIR_RIGHT] = res_id;

      for (int b = 0; b < NDIR; b++) begin
         bank_ctl[b].rd_en = (state_ff == tdar_pkg::ST_RESOLVE) ||
                             (state_ff == tdar_pkg::ST_QUERY);
         bank_ctl[b].wr_en = update_fire && ((b < 2) ? link_up_ff : link_left_ff);
         bank_ctl[b].clear = other_fire && (op_ff == tdar_pkg::OP_CLEAR);
         bank_wdata[b]     = bank_rdata[b] | (MAX_IDS'(1) << bit_ff[b]);
      end
   end

   // result word contents
   always_comb begin
      qid_ok         = QCMP_W'(qid_ff) < QCMP_W'(MAX_IDS);
      rsp_tile_id_in = '0;
      rsp_is_new_in  = 1'b0;
      rsp_ovf_in     = 1'b0;
      rsp_last_in    = 1'b0;
      rsp_row_in     = '0;
      rsp_count_in   = CNTO_W'(ids_used_ff);
      case (state_ff)
         tdar_pkg::ST_UPDATE: begin
            rsp_tile_id_in = TID_W'(tid_ff);
            rsp_is_new_in  = new_ff;
            rsp_ovf_in     = ovf_ff;
            rsp_last_in    = col_wrap && row_wrap;
         end
         tdar_pkg::ST_QOUT: begin
            // ids past the table read as an empty row
            rsp_row_in = qid_ok ? ROW_W'(bank_rdata[qdir_ff]) : '0;
         end
         tdar_pkg::ST_OTHER: begin
            if (op_ff == tdar_pkg::OP_CLEAR) begin
               rsp_count_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdar_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // input word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= tdar_pkg::op_type'(req_op);
         key_ff  <= req_tile_key[KW-1:0];
         qid_ff  <= req_query_id;
         qdir_ff <= req_query_dir;
      end
   end

   // resolved tile and the bank rows it will write
   always_ff @(posedge clock) begin
      if (state_ff == tdar_pkg::ST_RESOLVE) begin
         tid_ff       <= res_id;
         new_ff       <= !chain_found;
         ovf_ff       <= res_ovf;
         rec_ff       <= res_rec;
         link_up_ff   <= link_up;
         link_left_ff <= link_left;
         for (int b = 0; b < NDIR; b++) begin
            addr_ff[b] <= bank_rd_addr[b];
            bit_ff[b]  <= link_bit[b];
         end
      end
   end

   // line buffer: read at the tile's column, rewritten when the tile retires
   always_ff @(posedge clock) begin
      if (state_ff == tdar_pkg::ST_MATCH) begin
         lb_rd_ff <= lb_mem[col_ff];
      end
      if (update_fire) begin
         lb_mem[col_ff] <= {rec_ff, tid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (update_fire) begin
         left_id_ff <= tid_ff;
      end
   end

   // id count, raster position, left validity and grid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ids_used_ff   <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         left_valid_ff <= 1'b0;
         cols_ff       <= tdar_pkg::GRID_RESET;
         rows_ff       <= tdar_pkg::GRID_RESET;
      end else begin
         if (chain_ctl.insert) begin
            ids_used_ff <= ids_used_ff + IUW'(1);
         end
         if (update_fire) begin
            if (col_wrap) begin
               // end of row, and after the last row back to the top left
               col_ff        <= '0;
               left_valid_ff <= 1'b0;
               row_ff        <= row_wrap ? '0 : row_ff + RP_W'(1);
            end else begin
               col_ff        <= col_ff + COL_W'(1);
               left_valid_ff <= rec_ff;
            end
         end
         if (other_fire && (op_ff == tdar_pkg::OP_CLEAR)) begin
            ids_used_ff   <= '0;
            col_ff        <= '0;
            row_ff        <= '0;
            left_valid_ff <= 1'b0;
         end
         if (csr_wen) begin
            case (csr_index)
               tdar_pkg::CSR_GRID_COLUMNS: cols_ff <= csr_wdata;
               tdar_pkg::CSR_GRID_ROWS:    rows_ff <= csr_wdata;
               default: ;
            endcase
            // any grid change restarts the image position
            col_ff        <= '0;
            row_ff        <= '0;
            left_valid_ff <= 1'b0;
         end
      end
   end

   // result register: loads when free, so the next word can enter while it waits
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tile_id_ff <= rsp_tile_id_in;
         rsp_is_new_ff  <= rsp_is_new_in;
         rsp_ovf_ff     <= rsp_ovf_in;
         rsp_last_ff    <= rsp_last_in;
         rsp_row_ff     <= rsp_row_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tile_id        = rsp_tile_id_ff;
   assign rsp_is_new         = rsp_is_new_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_last_tile      = rsp_last_ff;
   assign rsp_allowed_row    = rsp_row_ff;
   assign rsp_distinct_count = rsp_count_ff;

   tdar_key_chain #(
      .N   (MAX_IDS),
      .KW  (KW),
      .IDW (IDW),
      .IUW (IUW)
   ) u_key_chain (
      .clock    (clock),
      .reset    (reset),
      .ctl      (chain_ctl),
      .key      (key_ff),
      .new_id   (ids_used_ff[IDW-1:0]),
      .ids_used (ids_used_ff),
      .found    (chain_found),
      .match_id (chain_id)
   );

   // one bank per direction, so a tile does at most one write to each
   for (genvar b = 0; b < NDIR; b++) begin : g_bank
      tdar_rule_bank #(
         .DEPTH (MAX_IDS),
         .AW    (IDW),
         .WIDTH (MAX_IDS)
      ) u_bank (
         .clock   (clock),
         .reset   (reset),
         .ctl     (bank_ctl[b]),
         .rd_addr (bank_rd_addr[b]),
         .wr_addr (addr_ff[b]),
         .wr_data (bank_wdata[b]),
         .rd_data (bank_rdata[b])
      );
   end

   // id count never passes the table size
   `TDAR_ASSERT_IMP(a_ids_bound, clock, reset, 1'b1, ids_used_ff <= IUW'(MAX_IDS))
   // raster column always inside the configured grid
   `TDAR_ASSERT_IMP(a_col_bound, clock, reset, 1'b1, CNT_W'(col_ff) < eff_cols)
   // a known key takes no new id
   `TDAR_ASSERT_NEXT(a_hit_no_alloc, clock, reset, (state_ff == tdar_pkg::ST_RESOLVE) && chain_found, $stable(ids_used_ff))
   // overflow only with every id taken
   `TDAR_ASSERT_IMP(a_ovf_full, clock, reset, rsp_valid_ff && rsp_ovf_ff, rsp_is_new_ff && (rsp_count_ff == CNTO_W'(MAX_IDS)))

endmodule
`default_nettype wire
